/* rtl/core/tsprx_pkg.sv */
`default_nettype none
package tsprx_pkg;

   localparam int BIT_PERIOD_W = 16;
   localparam int GAP_BITS_W   = 6;
   localparam int TICK_W       = 24;
   localparam int CSR_DATA_W   = 16;
   localparam int CHANNEL_W    = 11;
   localparam int BYTE_W       = 8;

   localparam logic [BIT_PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd2000;
   localparam logic [GAP_BITS_W-1:0]   GAP_BITS_RESET   = 6'd20;

   // register indexes on the write port
   typedef enum logic [0:0] {
      CSR_BIT_PERIOD = 1'b0,
      CSR_GAP_BITS   = 1'b1
   } csr_index_type;

   // one result request
   typedef struct packed {
      logic [CHANNEL_W-1:0] first_channel;
      logic [BYTE_W-1:0]    last_byte;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

/* rtl/core/tsprx_front.sv */
`default_nettype none
module tsprx_front #(
   parameter int PACKET_BYTES = 25
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  sample_valid,
   input  wire logic                                  pin_level,
   input  wire logic [tsprx_pkg::BIT_PERIOD_W-1:0]    bit_period,
   input  wire logic [tsprx_pkg::GAP_BITS_W-1:0]      gap_bits,
   output logic                                       push_valid,
   output tsprx_pkg::result_type                      push_data
);

   typedef enum logic [1:0] {
      ST_WAIT = 2'b01,
      ST_RECV = 2'b10
   } state_type;

   localparam logic [5:0] LAST_BYTE_IDX = 6'(PACKET_BYTES - 1);
   localparam logic [3:0] BIT_FIRST     = 4'd1;
   localparam logic [3:0] BIT_END       = 4'd9;
   localparam int         TW            = tsprx_pkg::TICK_W;

   state_type     state_ff, state_in;
   logic [TW-1:0] tick_ff, tick_in;
   logic [3:0]    bit_index_ff, bit_index_in;
   logic [7:0]    shift_ff, shift_in;
   logic [5:0]    byte_index_ff, byte_index_in;
   logic [7:0]    byte_one_ff, byte_one_in;
   logic [7:0]    byte_two_ff, byte_two_in;

   logic [TW-1:0] tick_next;
   logic [19:0]   bit_product;
   logic [20:0]   bit_thresh;
   logic [21:0]   gap_limit;
   logic          point_hit;
   logic          gap_hit;
   logic [7:0]    one_eff;
   logic [7:0]    two_eff;

   assign tick_next   = (tick_ff == {TW{1'b1}}) ? tick_ff : tick_ff + 1'b1;
   assign bit_product = {4'd0, bit_period} * {16'd0, bit_index_ff};
   assign bit_thresh  = {1'b0, bit_product} + {6'd0, bit_period[15:1]};
   assign point_hit   = tick_next >= {3'd0, bit_thresh};
   assign gap_limit   = {6'd0, bit_period} * {16'd0, gap_bits};
   assign gap_hit     = tick_ff > {2'd0, gap_limit};

   // byte two may land in the same tick as the result for short packets
   assign one_eff = (byte_index_ff == 6'd1) ? shift_ff : byte_one_ff;
   assign two_eff = (byte_index_ff == 6'd2) ? shift_ff : byte_two_ff;

   always_comb begin
      state_in      = state_ff;
      tick_in       = tick_ff;
      bit_index_in  = bit_index_ff;
      shift_in      = shift_ff;
      byte_index_in = byte_index_ff;
      byte_one_in   = byte_one_ff;
      byte_two_in   = byte_two_ff;
      push_valid    = 1'b0;
      push_data.first_channel = {one_eff, 3'b000} | {8'd0, two_eff[7:5]};
      push_data.last_byte     = shift_ff;
      if (sample_valid) begin
         unique case (state_ff)
            ST_WAIT: begin
               if (pin_level) begin
                  state_in     = ST_RECV;
                  tick_in      = '0;
                  bit_index_in = BIT_FIRST;
                  shift_in     = '0;
               end else if (gap_hit) begin
                  byte_index_in = '0;
                  tick_in       = '0;
               end else begin
                  tick_in = tick_next;
               end
            end
            ST_RECV: begin
               tick_in = tick_next;
               if (bit_index_ff != BIT_END) begin
                  if (point_hit) begin
                     shift_in     = {shift_ff[6:0], pin_level};
                     bit_index_in = bit_index_ff + 4'd1;
                  end
               end else if (point_hit) begin
                  state_in     = ST_WAIT;
                  tick_in      = '0;
                  bit_index_in = BIT_FIRST;
                  byte_one_in  = one_eff;
                  byte_two_in  = two_eff;
                  if (byte_index_ff >= LAST_BYTE_IDX) begin
                     byte_index_in = '0;
                     push_valid    = 1'b1;
                  end else begin
                     byte_index_in = byte_index_ff + 6'd1;
                  end
               end
            end
            default: begin
               state_in = ST_WAIT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_WAIT;
         tick_ff       <= '0;
         bit_index_ff  <= BIT_FIRST;
         shift_ff      <= '0;
         byte_index_ff <= '0;
         byte_one_ff   <= '0;
         byte_two_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         bit_index_ff  <= bit_index_in;
         shift_ff      <= shift_in;
         byte_index_ff <= byte_index_in;
         byte_one_ff   <= byte_one_in;
         byte_two_ff   <= byte_two_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/tsprx_queue.sv */
`default_nettype none
module tsprx_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  tsprx_pkg::result_type        push_data,
   input  wire logic                    pop,
   output tsprx_pkg::result_type        pop_data,
   output tsprx_pkg::queue_status_type  status
);

   // two entries
   tsprx_pkg::result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/tsprx_back.sv */
`default_nettype none
module tsprx_back (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  tsprx_pkg::queue_status_type                queue_status,
   input  tsprx_pkg::result_type                      queue_data,
   output logic                                       queue_pop,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [tsprx_pkg::CHANNEL_W-1:0]            rsp_first_channel,
   output logic [tsprx_pkg::BYTE_W-1:0]               rsp_last_byte
);

   logic                  valid_ff, valid_in;
   tsprx_pkg::result_type data_ff;

   // refill the output register when it is empty or being taken
   assign queue_pop = !queue_status.empty && (!valid_ff || rsp_ready);
   assign valid_in  = queue_pop || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         data_ff <= queue_data;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_first_channel = data_ff.first_channel;
   assign rsp_last_byte     = data_ff.last_byte;

endmodule
`default_nettype wire

/* rtl/core/timed_serial_packet_receiver_core.sv */
// Result path: the sample ending the last byte of a packet pushes a result request into
//    the result queue; it then moves to the output register, which drives rsp_valid.
// Throughput: one pin sample per cycle; req_ready drops only while the
//    two-entry result queue is full behind a stalled output register.
// Reset: synchronous, active high; clears the receiver state, the queue and the
//    output valid, and loads bit_period = 2000, gap_bits = 20.
`default_nettype none
module timed_serial_packet_receiver_core #(
   parameter int PACKET_BYTES = 25
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // sample requests
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_pin_level,
   // result requests
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [tsprx_pkg::CHANNEL_W-1:0]            rsp_first_channel,
   output logic [tsprx_pkg::BYTE_W-1:0]               rsp_last_byte,
   // register writes
   input  wire logic                                  csr_write_enable,
   input  wire logic [0:0]                            csr_index,
   input  wire logic [tsprx_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   logic [tsprx_pkg::BIT_PERIOD_W-1:0] bit_period_ff;
   logic [tsprx_pkg::GAP_BITS_W-1:0]   gap_bits_ff;

   logic                               sample_accept;
   logic                               front_push;
   tsprx_pkg::result_type              front_data;
   logic                               queue_pop;
   tsprx_pkg::result_type              queue_data;
   tsprx_pkg::queue_status_type        queue_status;

   // Configuration registers: written straight from the port, no read-back.
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff <= tsprx_pkg::BIT_PERIOD_RESET;
         gap_bits_ff   <= tsprx_pkg::GAP_BITS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tsprx_pkg::CSR_BIT_PERIOD: bit_period_ff <= csr_write_data;
            tsprx_pkg::CSR_GAP_BITS:   gap_bits_ff   <= csr_write_data[5:0];
         endcase
      end
   end

   // The front only ever pushes into a queue that has room, so a full queue
   // holds off the sample stream; otherwise a sample is taken every cycle.
   assign req_ready     = !queue_status.full;
   assign sample_accept = req_valid && req_ready;

   // Front: tick counter, bit sampling and byte/packet bookkeeping.
   tsprx_front #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .sample_valid (sample_accept),
      .pin_level    (req_pin_level),
      .bit_period   (bit_period_ff),
      .gap_bits     (gap_bits_ff),
      .push_valid   (front_push),
      .push_data    (front_data)
   );

   // Short queue decoupling the front from a stalled result channel.
   tsprx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_data),
      .pop       (queue_pop),
      .pop_data  (queue_data),
      .status    (queue_status)
   );

   // Back: output register on the result channel.
   tsprx_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_status      (queue_status),
      .queue_data        (queue_data),
      .queue_pop         (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_first_channel (rsp_first_channel),
      .rsp_last_byte     (rsp_last_byte)
   );

`ifndef SYNTHESIS
   // a result is never pushed into a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      front_push |-> !queue_status.full)
      else $error("result pushed into full queue");

   // a result into an empty queue and idle back end reaches the port via the output register
   a_push_reaches_port: assert property (@(posedge clock) disable iff (reset)
      (front_push && queue_status.empty && !rsp_valid) |-> ##2 rsp_valid)
      else $error("result did not reach the output");

   // with the queue full behind a stalled output, samples stay held off
   a_full_holds_off: assert property (@(posedge clock) disable iff (reset)
      (queue_status.full && rsp_valid && !rsp_ready) |=> !req_ready)
      else $error("sample stream released while queue still full");
`endif

endmodule
`default_nettype wire
